[hdl/rfr_pkg.sv]
// ----------------------------------------------------------------------------
// rfr_pkg
// Types, codes and helpers shared by the reply frame receiver modules.
// ----------------------------------------------------------------------------
package rfr_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h7E;
    localparam logic [7:0]  END_BYTE      = 8'hEF;
    localparam logic [7:0]  ERR_CMD       = 8'h40;
    localparam logic [15:0] TIMEOUT_RESET = 16'd800;

    localparam logic [7:0]  MERR_CHK_A    = 8'h03;
    localparam logic [7:0]  MERR_CHK_B    = 8'h04;
    localparam logic [7:0]  MERR_NOCARD   = 8'h06;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_CMD     = 4'd3;
    localparam logic [3:0] POS_PARAM_H = 4'd5;
    localparam logic [3:0] POS_PARAM_L = 4'd6;
    localparam logic [3:0] POS_LAST    = 4'd9;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NORESP    = 3'd1,
        ST_PARTIAL   = 3'd2,
        ST_CHKBAD    = 3'd3,
        ST_BUSY      = 3'd4,
        ST_FRAME_ERR = 3'd5,
        ST_NOCARD    = 3'd6
    } status_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  cmd;
        logic [15:0] param;
        logic [7:0]  merr;
    } result_t;

    function automatic status_t map_module_error(input logic [7:0] code);
        status_t st;
        unique case (code)
            MERR_CHK_A, MERR_CHK_B: st = ST_CHKBAD;
            MERR_NOCARD:            st = ST_NOCARD;
            default:                st = ST_BUSY;
        endcase
        return st;
    endfunction

endpackage

[hdl/rfr_frame_parser.sv]
// ----------------------------------------------------------------------------
// rfr_frame_parser
// Byte hunter, frame collector, checksum check and tick timeout window.
// ----------------------------------------------------------------------------
module rfr_frame_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             item_accept,
    input  logic             action,
    input  logic [7:0]       rx_byte,
    output rfr_pkg::result_t res
);
    import rfr_pkg::*;

    logic [15:0] timeout_reg;
    logic [3:0]  pos_reg,   pos_next;
    logic [15:0] sum_reg,   sum_next;
    logic [7:0]  cmd_reg,   cmd_next;
    logic [15:0] param_reg, param_next;
    logic [15:0] check_reg, check_next;
    logic [15:0] tick_reg,  tick_next;
    logic [16:0] tick_inc;
    logic [15:0] expected;

    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign expected = 16'(17'h10000 - {1'b0, sum_reg});

    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        cmd_next   = cmd_reg;
        param_next = param_reg;
        check_next = check_reg;
        tick_next  = tick_reg;
        res        = '0;
        res.status = ST_OK;
        if (item_accept) begin
            if (action == ACT_TICK) begin
                if (tick_inc >= {1'b0, timeout_reg}) begin
                    res.valid  = 1'b1;
                    res.status = (pos_reg != POS_HUNT) ? ST_PARTIAL : ST_NORESP;
                    pos_next   = POS_HUNT;
                    sum_next   = '0;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc[15:0];
                end
            end else if (pos_reg == POS_HUNT) begin
                if (rx_byte == SYNC_BYTE) begin
                    pos_next = 4'd1;
                    sum_next = '0;
                end
            end else if (pos_reg <= POS_PARAM_L) begin
                sum_next = sum_reg + {8'd0, rx_byte};
                if (pos_reg == POS_CMD) begin
                    cmd_next = rx_byte;
                end else if (pos_reg == POS_PARAM_H || pos_reg == POS_PARAM_L) begin
                    param_next = {param_reg[7:0], rx_byte};
                end
                pos_next = pos_reg + 4'd1;
            end else if (pos_reg < POS_LAST) begin
                check_next = {check_reg[7:0], rx_byte};
                pos_next   = pos_reg + 4'd1;
            end else if (rx_byte != END_BYTE) begin
                pos_next = POS_HUNT;
                sum_next = '0;
            end else begin
                res.valid = 1'b1;
                res.cmd   = cmd_reg;
                res.param = param_reg;
                if (expected != check_reg) begin
                    res.status = ST_CHKBAD;
                end else if (cmd_reg == ERR_CMD) begin
                    res.merr   = param_reg[7:0];
                    res.status = map_module_error(param_reg[7:0]);
                end else begin
                    res.status = ST_OK;
                end
                pos_next  = POS_HUNT;
                sum_next  = '0;
                tick_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            pos_reg     <= POS_HUNT;
            sum_reg     <= '0;
            cmd_reg     <= '0;
            param_reg   <= '0;
            check_reg   <= '0;
            tick_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            param_reg <= param_next;
            check_reg <= check_next;
            tick_reg  <= tick_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("byte position beyond last frame byte");

    a_result_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (pos_reg == POS_HUNT && tick_reg == '0 && sum_reg == '0))
        else $error("window not restarted after result");

    a_noresp_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.status == ST_NORESP) |-> (pos_reg == POS_HUNT))
        else $error("no-response result while a frame is in progress");

    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && (res.status == ST_NORESP || res.status == ST_PARTIAL))
            |-> (res.cmd == '0 && res.param == '0 && res.merr == '0))
        else $error("timeout result carries frame data");

endmodule

[hdl/rfr_out_stage.sv]
// ----------------------------------------------------------------------------
// rfr_out_stage
// Result register on the m_ side; frees the input while a result is taken.
// ----------------------------------------------------------------------------
module rfr_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  rfr_pkg::result_t res,
    output logic             in_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_reply_cmd,
    output logic [15:0]      m_reply_param,
    output logic [7:0]       m_module_error
);
    import rfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res.valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = data_reg.status;
    assign m_reply_cmd    = data_reg.cmd;
    assign m_reply_param  = data_reg.param;
    assign m_module_error = data_reg.merr;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> in_ready)
        else $error("result loaded over an untaken result");

    a_ready_only_blocked_by_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (valid_reg && !m_ready))
        else $error("input stalled without an output stall");

    a_loaded_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> valid_reg)
        else $error("loaded result not presented");

endmodule

[hdl/reply_frame_receiver.sv]
// ----------------------------------------------------------------------------
// reply_frame_receiver
// Hunts 10-byte reply frames in a byte stream and times out on ticks.
// ----------------------------------------------------------------------------
// Input channel s_: each item is either a received byte (s_action = 0,
// s_rx_byte) or one timer tick (s_action = 1). Result channel m_: status,
// command, parameter and module error code of a finished frame or timeout.
// Most items give no result; a good end byte or an expiring window gives one.
// cfg_wr_en / cfg_wr_data write the timeout window length in ticks.
// A result appears on m_ the cycle after the item that causes it.
// Throughput: one item per cycle while s_ready is high; the frame state
// updates with each accepted item and the only stage is the result register.
// Reset: hunting for a start byte, tick count zero, window length 800.
// Stall: while a result waits on m_ with m_ready low, s_ready drops; it
// returns the same cycle m_ready rises.
// ----------------------------------------------------------------------------
module reply_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_reply_cmd,
    output logic [15:0] m_reply_param,
    output logic [7:0]  m_module_error
);
    import rfr_pkg::*;

    result_t res;
    logic    item_accept;

    assign item_accept = s_valid && s_ready;

    rfr_frame_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_accept (item_accept),
        .action      (s_action),
        .rx_byte     (s_rx_byte),
        .res         (res)
    );

    rfr_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res            (res),
        .in_ready       (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_reply_cmd    (m_reply_cmd),
        .m_reply_param  (m_reply_param),
        .m_module_error (m_module_error)
    );

endmodule
